// ===== design/cef_pkg.sv =====
// cef_pkg: shared types and constants of the coalescing event FIFO.
// Used by cef_ctrl, cef_datapath and coalescing_event_fifo_unit; no dependencies.
`timescale 1ns / 1ps

package cef_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int ENTRY_W       = 56;
    localparam int FILL_OUT_W    = 7;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MERGE_MOVES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MOVE_TYPE   = 1'b1;

    // op codes carried on s_tuser
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    // one stored event, event type in the lowest bits
    typedef struct packed {
        logic signed [15:0] second;
        logic signed [15:0] first;
        logic        [15:0] code;
        logic        [7:0]  ev_type;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input beat and start the store read
        logic commit;   // update store and indices, load the result register
    } cef_cmd_t;

endpackage

// ===== design/coalescing_event_fifo_unit.sv =====
// coalescing_event_fifo_unit: top level of the coalescing event FIFO.
// Instantiates cef_ctrl and cef_datapath; depends on cef_pkg.
//
//   channel  | dir | tdata                                   | tuser
//   s_       | in  | type, code, delta_x, delta_y (56 bits)  | op
//   m_       | out | type, code, first, second, fill (64)    | got, merged, dropped
//   cfg_     | in  | index 0 merge_moves, index 1 move_type  | -
//
// Each beat is handled in two steps: the first reads the event store (synchronous
// single-port read), the second does the merge add / append and writes back.
// A result waits in an output register; while it is not taken the next beat
// is still captured and its read done, and it commits once the register frees.
// aresetn clears the ring indices and config (merge on, move type 1); the store is not cleared.
`timescale 1ns / 1ps

module coalescing_event_fifo_unit #(
    parameter int DEPTH = cef_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] event_type, [23:8] event_code, [39:24] delta_x, [55:40] delta_y
    input  logic [55:0]                    s_tdata,
    // [0] op
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_type, [23:8] out_code, [39:24] out_first, [55:40] out_second,
    // [62:56] fill_count, [63] zero
    output logic [63:0]                    m_tdata,
    // [0] got_event, [1] was_merged, [2] was_dropped
    output logic [2:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [cef_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cef_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    cef_pkg::cef_cmd_t cmd;
    cef_pkg::entry_t   in_entry, out_entry;
    logic [cef_pkg::FILL_OUT_W-1:0] out_fill;
    logic out_got, out_merged, out_dropped;

    assign in_entry = cef_pkg::entry_t'(s_tdata);

    cef_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cef_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_op       (s_tuser),
        .in_entry    (in_entry),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .out_entry   (out_entry),
        .out_fill    (out_fill),
        .out_got     (out_got),
        .out_merged  (out_merged),
        .out_dropped (out_dropped)
    );

    assign m_tdata = {1'b0, out_fill, out_entry};
    assign m_tuser = {out_dropped, out_merged, out_got};

endmodule

// ===== design/cef_ctrl.sv =====
// cef_ctrl: two-state controller of the coalescing event FIFO, owns both handshakes.
// Depends on cef_pkg.
`timescale 1ns / 1ps

module cef_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cef_pkg::cef_cmd_t cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold here until the result register can take the new beat
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/cef_datapath.sv =====
// cef_datapath: event store memory, ring indices, config registers, merge adders
// and the result register. Depends on cef_pkg.
`timescale 1ns / 1ps

module cef_datapath #(
    parameter int DEPTH = cef_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cef_pkg::cef_cmd_t                cmd,
    input  logic                             in_op,
    input  cef_pkg::entry_t                  in_entry,
    input  logic                             cfg_we,
    input  logic [cef_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cef_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output cef_pkg::entry_t                  out_entry,
    output logic [cef_pkg::FILL_OUT_W-1:0]   out_fill,
    output logic                             out_got,
    output logic                             out_merged,
    output logic                             out_dropped
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = (IDX_W > cef_pkg::FILL_OUT_W) ? IDX_W : cef_pkg::FILL_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    cef_pkg::entry_t mem [DEPTH];

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             merge_en_reg;
    logic [7:0]       move_type_reg;

    logic             op_reg;
    cef_pkg::entry_t  item_reg;
    cef_pkg::entry_t  rd_data_reg;

    cef_pkg::entry_t  res_entry_reg;
    logic [cef_pkg::FILL_OUT_W-1:0] res_fill_reg;
    logic             res_got_reg, res_merged_reg, res_dropped_reg;

    logic [IDX_W-1:0] newest, wr_adv, rd_adv, rd_addr, mem_waddr;
    logic             nonempty, do_merge, do_append, do_drop, do_pop, mem_we;
    cef_pkg::entry_t  mem_wdata, merged_entry, res_entry;
    logic [FILL_W-1:0] fill;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        begin
            s = {a[15], a} + {b[15], b};
            if (s[16] != s[15])
                sat_add = s[16] ? cef_pkg::SAT_MIN : cef_pkg::SAT_MAX;
            else
                sat_add = s[15:0];
        end
    endfunction

    assign newest   = (wr_idx_reg == '0) ? LAST_IDX : wr_idx_reg - 1'b1;
    assign wr_adv   = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_adv   = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign nonempty = (wr_idx_reg != rd_idx_reg);
    // a get reads the oldest entry, a put reads the newest for a possible merge
    assign rd_addr  = (in_op == cef_pkg::OP_GET) ? rd_idx_reg : newest;

    always_comb begin
        merged_entry        = rd_data_reg;
        merged_entry.first  = sat_add(rd_data_reg.first, item_reg.first);
        merged_entry.second = sat_add(rd_data_reg.second, item_reg.second);

        do_merge  = (op_reg == cef_pkg::OP_PUT) && merge_en_reg && nonempty
                    && (item_reg.ev_type == move_type_reg)
                    && (rd_data_reg.ev_type == move_type_reg);
        do_append = (op_reg == cef_pkg::OP_PUT) && !do_merge && (wr_adv != rd_idx_reg);
        do_drop   = (op_reg == cef_pkg::OP_PUT) && !do_merge && (wr_adv == rd_idx_reg);
        do_pop    = (op_reg == cef_pkg::OP_GET) && nonempty;

        mem_we    = cmd.commit && (do_merge || do_append);
        mem_waddr = do_merge ? newest : wr_idx_reg;
        mem_wdata = do_merge ? merged_entry : item_reg;

        wr_idx_next = do_append ? wr_adv : wr_idx_reg;
        rd_idx_next = do_pop ? rd_adv : rd_idx_reg;

        if (wr_idx_next >= rd_idx_next)
            fill = FILL_W'(wr_idx_next) - FILL_W'(rd_idx_next);
        else
            fill = FILL_W'(DEPTH) - FILL_W'(rd_idx_next) + FILL_W'(wr_idx_next);

        res_entry = do_pop ? rd_data_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture)
            rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            item_reg <= in_entry;
        end
        if (cmd.commit) begin
            res_entry_reg   <= res_entry;
            res_fill_reg    <= fill[cef_pkg::FILL_OUT_W-1:0];
            res_got_reg     <= do_pop;
            res_merged_reg  <= do_merge;
            res_dropped_reg <= do_drop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            merge_en_reg  <= 1'b1;
            move_type_reg <= 8'd1;
        end else begin
            if (cmd.commit) begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    cef_pkg::REG_MERGE_MOVES: merge_en_reg  <= cfg_wdata[0];
                    cef_pkg::REG_MOVE_TYPE:   move_type_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign out_entry   = res_entry_reg;
    assign out_fill    = res_fill_reg;
    assign out_got     = res_got_reg;
    assign out_merged  = res_merged_reg;
    assign out_dropped = res_dropped_reg;

endmodule
